>>> hw/rtl/hsvrgb_pkg.sv
// Package with the types and constants shared by the HSV to RGB converter.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int HUE_W  = 13;
    localparam int FRAC_W = 8;
    localparam int F_W    = 10;
    localparam int PROD_W = 18;
    localparam int NUM_W  = 26;
    localparam int QUO_W  = 20;
    localparam int RECIP_W = 21;

    localparam logic [HUE_W-1:0]   HUE_FULL   = 13'd5760;
    localparam logic [F_W-1:0]     HUE_SECTOR = 10'd960;
    localparam logic [FRAC_W-1:0]  FRAC_ONE   = 8'd255;
    localparam logic [PROD_W-1:0]  SECTOR_ONE = 18'd244800;
    // Reciprocal of 3825 scaled by 2^32, rounded up; exact for 20-bit numerators.
    localparam logic [RECIP_W-1:0] RECIP_3825 = 21'd1122868;
    localparam logic [9:0]         RECIP_255  = 10'd257;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector           sector;
        logic [F_W-1:0]    frac;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
    } t_sec_data;

    typedef struct packed {
        t_sector           sector;
        logic [FRAC_W-1:0] val;
        logic [FRAC_W-1:0] sat_inv;
        logic [PROD_W-1:0] sf_q;
        logic [PROD_W-1:0] sf_t;
    } t_prod_data;

    typedef struct packed {
        t_sector           sector;
        logic [FRAC_W-1:0] val;
        logic [15:0]       num_p;
        logic [NUM_W-1:0]  num_q;
        logic [NUM_W-1:0]  num_t;
    } t_num_data;

    typedef struct packed {
        t_sector           sector;
        logic [FRAC_W-1:0] val;
        logic [FRAC_W-1:0] p;
        logic [FRAC_W-1:0] q;
        logic [FRAC_W-1:0] t;
    } t_chan_data;

endpackage

>>> hw/rtl/hsvrgb_sector.sv
// First pipeline stage: hue wrap, sector number and position within the sector.
`timescale 1ns / 1ps

module hsvrgb_sector
    import hsvrgb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_ready,
    input  logic [HUE_W-1:0]  i_hue,
    input  logic [FRAC_W-1:0] i_sat,
    input  logic [FRAC_W-1:0] i_val,
    output logic              o_vld,
    input  logic              i_ready,
    output t_sec_data         o_data
);

    logic            r_vld;
    t_sec_data       r_data;
    t_sec_data       n_data;
    logic [HUE_W-1:0] hue_w;
    logic [HUE_W-1:0] base;

    always_comb begin
        hue_w = (i_hue >= HUE_FULL) ? '0 : i_hue;
        if (hue_w >= 13'd4800) begin
            n_data.sector = SEC_MAGENTA;
            base = 13'd4800;
        end else if (hue_w >= 13'd3840) begin
            n_data.sector = SEC_BLUE;
            base = 13'd3840;
        end else if (hue_w >= 13'd2880) begin
            n_data.sector = SEC_CYAN;
            base = 13'd2880;
        end else if (hue_w >= 13'd1920) begin
            n_data.sector = SEC_GREEN;
            base = 13'd1920;
        end else if (hue_w >= {3'b000, HUE_SECTOR}) begin
            n_data.sector = SEC_YELLOW;
            base = {3'b000, HUE_SECTOR};
        end else begin
            n_data.sector = SEC_RED;
            base = '0;
        end
        n_data.frac = F_W'(hue_w - base);
        n_data.sat  = i_sat;
        n_data.val  = i_val;
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

>>> hw/rtl/hsvrgb_mult.sv
// Two pipeline stages: saturation products, then numerators scaled by value.
`timescale 1ns / 1ps

module hsvrgb_mult
    import hsvrgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    output logic       o_ready,
    input  t_sec_data  i_data,
    output logic       o_vld,
    input  logic       i_ready,
    output t_num_data  o_data
);

    logic       r_vld_a;
    t_prod_data r_data_a;
    t_prod_data n_data_a;
    logic       ready_a;
    logic       r_vld_b;
    t_num_data  r_data_b;
    t_num_data  n_data_b;
    logic       ready_b;
    logic [PROD_W-1:0] sub_q;
    logic [PROD_W-1:0] sub_t;

    always_comb begin
        n_data_a.sector  = i_data.sector;
        n_data_a.val     = i_data.val;
        n_data_a.sat_inv = FRAC_ONE - i_data.sat;
        n_data_a.sf_q    = {{(PROD_W-FRAC_W){1'b0}}, i_data.sat}
                         * {{(PROD_W-F_W){1'b0}}, i_data.frac};
        n_data_a.sf_t    = {{(PROD_W-FRAC_W){1'b0}}, i_data.sat}
                         * {{(PROD_W-F_W){1'b0}}, F_W'(HUE_SECTOR - i_data.frac)};
    end

    always_comb begin
        sub_q = SECTOR_ONE - r_data_a.sf_q;
        sub_t = SECTOR_ONE - r_data_a.sf_t;
        n_data_b.sector = r_data_a.sector;
        n_data_b.val    = r_data_a.val;
        n_data_b.num_p  = {8'b0, r_data_a.val} * {8'b0, r_data_a.sat_inv};
        n_data_b.num_q  = {{(NUM_W-FRAC_W){1'b0}}, r_data_a.val}
                        * {{(NUM_W-PROD_W){1'b0}}, sub_q};
        n_data_b.num_t  = {{(NUM_W-FRAC_W){1'b0}}, r_data_a.val}
                        * {{(NUM_W-PROD_W){1'b0}}, sub_t};
    end

    assign ready_b = !r_vld_b || i_ready;
    assign ready_a = !r_vld_a || ready_b;
    assign o_ready = ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_vld_a <= i_vld;
            end
            if (ready_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_vld) begin
            r_data_a <= n_data_a;
        end
        if (ready_b && r_vld_a) begin
            r_data_b <= n_data_b;
        end
    end

    assign o_vld  = r_vld_b;
    assign o_data = r_data_b;

endmodule

>>> hw/rtl/hsvrgb_div.sv
// Pipeline stage that divides the numerators by constants through reciprocal products.
`timescale 1ns / 1ps

module hsvrgb_div
    import hsvrgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    output logic       o_ready,
    input  t_num_data  i_data,
    output logic       o_vld,
    input  logic       i_ready,
    output t_chan_data o_data
);

    logic       r_vld;
    t_chan_data r_data;
    t_chan_data n_data;
    logic [25:0] prod_p;
    logic [40:0] prod_q;
    logic [40:0] prod_t;

    always_comb begin
        prod_p = ({10'b0, i_data.num_p} + 26'd1) * {16'b0, RECIP_255};
        prod_q = {{(41-QUO_W){1'b0}}, i_data.num_q[NUM_W-1:6]}
               * {{(41-RECIP_W){1'b0}}, RECIP_3825};
        prod_t = {{(41-QUO_W){1'b0}}, i_data.num_t[NUM_W-1:6]}
               * {{(41-RECIP_W){1'b0}}, RECIP_3825};
        n_data.sector = i_data.sector;
        n_data.val    = i_data.val;
        n_data.p      = prod_p[23:16];
        n_data.q      = prod_q[39:32];
        n_data.t      = prod_t[39:32];
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

>>> hw/rtl/hsv_to_rgb_converter_core.sv
// Throughput: one item per cycle while the master side accepts; five register stages,
// one multiplier level each at most, with per-stage ready so a stall fills bubbles
// before holding the input.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; data regs keep
// their contents.
// Top level of the HSV to RGB converter with the channel selection output stage.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core
    import hsvrgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // hue[12:0], saturation[20:13], brightness[28:21]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);

    logic       sec_vld;
    logic       sec_ready;
    t_sec_data  sec_data;
    logic       num_vld;
    logic       num_ready;
    t_num_data  num_data;
    logic       chan_vld;
    logic       chan_ready;
    t_chan_data chan_data;
    logic        r_vld;
    logic [23:0] r_rgb;
    logic [23:0] n_rgb;
    logic        out_ready;

    hsvrgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_hue   (s_axis_tdata[12:0]),
        .i_sat   (s_axis_tdata[20:13]),
        .i_val   (s_axis_tdata[28:21]),
        .o_vld   (sec_vld),
        .i_ready (sec_ready),
        .o_data  (sec_data)
    );

    hsvrgb_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sec_vld),
        .o_ready (sec_ready),
        .i_data  (sec_data),
        .o_vld   (num_vld),
        .i_ready (num_ready),
        .o_data  (num_data)
    );

    hsvrgb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (num_vld),
        .o_ready (num_ready),
        .i_data  (num_data),
        .o_vld   (chan_vld),
        .i_ready (chan_ready),
        .o_data  (chan_data)
    );

    always_comb begin
        case (chan_data.sector)
            SEC_RED:     n_rgb = {chan_data.p,   chan_data.t,   chan_data.val};
            SEC_YELLOW:  n_rgb = {chan_data.p,   chan_data.val, chan_data.q};
            SEC_GREEN:   n_rgb = {chan_data.t,   chan_data.val, chan_data.p};
            SEC_CYAN:    n_rgb = {chan_data.val, chan_data.q,   chan_data.p};
            SEC_BLUE:    n_rgb = {chan_data.val, chan_data.p,   chan_data.t};
            default:     n_rgb = {chan_data.q,   chan_data.p,   chan_data.val};
        endcase
    end

    assign out_ready  = !r_vld || m_axis_tready;
    assign chan_ready = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (out_ready) begin
            r_vld <= chan_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && chan_vld) begin
            r_rgb <= n_rgb;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_rgb;

endmodule

>>> bench/tb_hsv_to_rgb_converter_core.sv
// Self-checking testbench for the HSV to RGB converter core with an integer color predictor.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_core;
    import hsvrgb_pkg::*;

    localparam int RANDOM_ITEMS  = 800;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
        logic              known;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } t_color_row;

    // Columns: hue, saturation, value, expected known, red, green, blue.
    t_color_row color_rows [DIRECTED_ROWS] = '{
        '{13'd0,    8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{13'd0,    8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{13'd960,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},
        '{13'd1920, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
        '{13'd2880, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
        '{13'd3840, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
        '{13'd4800, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
        '{13'd5760, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{13'd8191, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{13'd1234, 8'd0,   8'd200, 1'b1, 8'd200, 8'd200, 8'd200},
        '{13'd8191, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        '{13'd0,    8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{13'd5759, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd959,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd480,  8'd128, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd1440, 8'd1,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd2400, 8'd200, 8'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd3360, 8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd4321, 8'd128, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd6000, 8'd77,  8'd99,  1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd5280, 8'd254, 8'd254, 1'b0, 8'd0,   8'd0,   8'd0},
        '{13'd7000, 8'd170, 8'd85,  1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    logic gold_known;
    t_rgb gold_rgb;
    t_rgb rgb_pending [$];
    int   rgb_errors  = 0;
    int   rgb_seen    = 0;
    int   cycle_count = 0;
    bit   sender_idle = 1'b1;
    bit   sink_idle   = 1'b1;
    bit   hold_request = 1'b0;

    hsv_to_rgb_converter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic t_rgb rgb_from_hsv(logic [HUE_W-1:0] hue, logic [FRAC_W-1:0] sat,
                                          logic [FRAC_W-1:0] val);
        int unsigned h, s, v, f, p, q, t;
        t_sector     sector;
        t_rgb        rgb;
        h = (hue >= HUE_FULL) ? 0 : hue;
        s = sat;
        v = val;
        sector = t_sector'(h / HUE_SECTOR);
        f = h % HUE_SECTOR;
        p = v * (FRAC_ONE - s) / FRAC_ONE;
        q = v * (SECTOR_ONE - s * f) / SECTOR_ONE;
        t = v * (SECTOR_ONE - s * (HUE_SECTOR - f)) / SECTOR_ONE;
        case (sector)
            SEC_RED:    {rgb.red, rgb.green, rgb.blue} = {v[7:0], t[7:0], p[7:0]};
            SEC_YELLOW: {rgb.red, rgb.green, rgb.blue} = {q[7:0], v[7:0], p[7:0]};
            SEC_GREEN:  {rgb.red, rgb.green, rgb.blue} = {p[7:0], v[7:0], t[7:0]};
            SEC_CYAN:   {rgb.red, rgb.green, rgb.blue} = {p[7:0], q[7:0], v[7:0]};
            SEC_BLUE:   {rgb.red, rgb.green, rgb.blue} = {t[7:0], p[7:0], v[7:0]};
            default:    {rgb.red, rgb.green, rgb.blue} = {v[7:0], p[7:0], q[7:0]};
        endcase
        return rgb;
    endfunction

    task automatic send_color(logic [HUE_W-1:0] hue, logic [FRAC_W-1:0] sat,
                              logic [FRAC_W-1:0] val, logic known, t_rgb rgb);
        if (sender_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, sat, hue};
        gold_known    <= known;
        gold_rgb      <= rgb;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic send_random_color();
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
        case ($urandom_range(0, 9))
            0: hue = HUE_W'($urandom_range(5760, 8191));
            1: hue = HUE_W'(960 * $urandom_range(0, 5) + 959 * $urandom_range(0, 1));
            default: hue = HUE_W'($urandom_range(0, 5759));
        endcase
        sat = ($urandom_range(0, 7) == 0) ? FRAC_W'(255 * $urandom_range(0, 1))
                                          : FRAC_W'($urandom_range(0, 255));
        val = ($urandom_range(0, 7) == 0) ? FRAC_W'(255 * $urandom_range(0, 1))
                                          : FRAC_W'($urandom_range(0, 255));
        send_color(hue, sat, val, 1'b0, '0);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (rgb_pending.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got = t_rgb'(m_axis_tdata);
            if (rgb_pending.size() == 0) begin
                rgb_errors++;
                if (rgb_errors <= REPORT_LIMIT)
                    $display("Unexpected result %0d: r=%0d g=%0d b=%0d",
                             rgb_seen, got.red, got.green, got.blue);
            end else begin
                want = rgb_pending.pop_front();
                if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue) begin
                    rgb_errors++;
                    if (rgb_errors <= REPORT_LIMIT)
                        $display("Result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 rgb_seen, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
            rgb_seen++;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            rgb_pending.push_back(gold_known ? gold_rgb
                : rgb_from_hsv(s_axis_tdata[12:0], s_axis_tdata[20:13], s_axis_tdata[28:21]));
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    initial begin
        t_rgb row_rgb;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        gold_known    <= 1'b0;
        gold_rgb      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (color_rows[i]) begin
            row_rgb.red   = color_rows[i].red;
            row_rgb.green = color_rows[i].green;
            row_rgb.blue  = color_rows[i].blue;
            send_color(color_rows[i].hue, color_rows[i].sat, color_rows[i].val,
                       color_rows[i].known, row_rgb);
        end

        for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
            case (idx)
                200: wait_for_results();
                250: begin
                    hold_request = 1'b1;
                    sender_idle  = 1'b0;
                end
                320: sender_idle = 1'b1;
                450: begin
                    sender_idle = 1'b0;
                    sink_idle   = 1'b0;
                end
                520: begin
                    sender_idle = 1'b1;
                    sink_idle   = 1'b1;
                end
                650: begin
                    sender_idle = 1'b0;
                    sink_idle   = 1'b0;
                end
                default: ;
            endcase
            send_random_color();
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (rgb_errors == 0 && rgb_pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> hsv_to_rgb_converter_core.f
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_sector.sv
hw/rtl/hsvrgb_mult.sv
hw/rtl/hsvrgb_div.sv
hw/rtl/hsv_to_rgb_converter_core.sv
bench/tb_hsv_to_rgb_converter_core.sv
